FILE: hdl/ffha_pkg.sv
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 24;

  localparam int ADDR_W = 17;
  localparam int REQ_W  = 16;
  localparam int ST_W   = 2;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOMEM   = 2'd2;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT_PREP,
    S_SHIFT_UP_RD,
    S_SHIFT_UP_WR,
    S_SPLIT_WR,
    S_GROW,
    S_FREE_NEXT_RD,
    S_FREE_NEXT_CHK,
    S_FREE_PREV_RD,
    S_FREE_PREV_CHK,
    S_CLOSE_RD,
    S_CLOSE_WR,
    S_OUT
  } ffha_state_t;

  // one table entry: header offset, data size, free mark
  typedef struct packed {
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] size;
    logic              is_free;
  } ffha_entry_t;

  localparam int ENTRY_W = 2 * ADDR_W + 1;

endpackage

FILE: hdl/ffha_if.sv
interface ffha_in_if;
  import ffha_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [REQ_W-1:0]  request_bytes;
  logic [ADDR_W-1:0] release_address;
  modport source (output valid, output command, output request_bytes,
                  output release_address, input ready);
  modport sink (input valid, input command, input request_bytes,
                input release_address, output ready);
endinterface

interface ffha_out_if;
  import ffha_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data_address;
  logic [ST_W-1:0]   status;
  modport source (output valid, output data_address, output status, input ready);
  modport sink (input valid, input data_address, input status, output ready);
endinterface

interface ffha_cfg_if;
  import ffha_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ffha_ram.sv
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ffha_ctrl.sv
module ffha_ctrl
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int IDX_W = $clog2(MAX_BLOCKS),
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  ffha_in_if.sink            in_ch,
  ffha_out_if.source         out_ch,
  ffha_cfg_if.sink           cfg_ch,
  output logic               ram_we,
  output logic [IDX_W-1:0]   ram_waddr,
  output ffha_entry_t        ram_wdata,
  output logic [IDX_W-1:0]   ram_raddr,
  input  ffha_entry_t        ram_rdata
);

  localparam int W = ADDR_W + 2;
  localparam logic [W-1:0] HDR = W'(HEADER_BYTES);
  localparam logic [W-1:0] HEAP_LIM = (HEAP_BYTES > 65536) ? W'(65536) : W'(HEAP_BYTES);

  ffha_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] limit_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] brk_r, brk_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              cmd_r;
  logic [W-1:0]      need_r;
  logic [ADDR_W-1:0] rel_r;
  ffha_entry_t       cur_r, cur_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic [ST_W-1:0]   ost_r, ost_nxt;
  logic              merged_r, merged_nxt;
  // close stride of two after merging with both neighbors
  logic              dbl_r;

  // shared adder / comparator
  logic [W-1:0] add_a, add_b, add_sum;
  assign add_sum = add_a + add_b;

  logic [W-1:0] need_in;
  assign need_in = (W'(in_ch.request_bytes) + W'(7)) & ~W'(7);

  logic [W-1:0] eff_lim;
  assign eff_lim = (W'(limit_r) < HEAP_LIM) ? W'(limit_r) : HEAP_LIM;

  logic in_acc;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data_address = oaddr_r;
  assign out_ch.status       = ost_r;

  always_comb begin
    add_a = W'(ram_rdata.offset);
    add_b = HDR;
    unique case (state_r)
      S_SPLIT_PREP:    begin add_a = W'(cur_r.offset); add_b = HDR + need_r; end
      S_SPLIT_WR:      begin add_a = W'(cur_r.size); add_b = ~(need_r + HDR) + W'(1); end
      S_GROW:          begin add_a = W'(brk_r); add_b = need_r + HDR; end
      S_FREE_NEXT_CHK,
      S_FREE_PREV_CHK: begin add_a = W'(cur_r.size) + W'(ram_rdata.size); add_b = HDR; end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_FREE) begin
            state_nxt = (in_ch.release_address == '0 || count_r == '0) ? S_OUT : S_SCAN_RD;
          end else if (in_ch.request_bytes == '0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = (count_r == '0) ? S_GROW : S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (cmd_r == CMD_ALLOC) begin
          if (ram_rdata.is_free && W'(ram_rdata.size) >= need_r) begin
            state_nxt = S_SPLIT_PREP;
          end else if (idx_r + CNT_W'(1) >= count_r) begin
            state_nxt = S_GROW;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end else begin
          if (add_sum == W'(rel_r)) begin
            state_nxt = ram_rdata.is_free ? S_OUT : S_FREE_NEXT_RD;
          end else if (idx_r + CNT_W'(1) >= count_r) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SPLIT_PREP: begin
        if (W'(cur_r.size) >= need_r + HDR + W'(8) && count_r < CNT_W'(MAX_BLOCKS)) begin
          state_nxt = (count_r > idx_r + CNT_W'(1)) ? S_SHIFT_UP_RD : S_SPLIT_WR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SHIFT_UP_RD: state_nxt = S_SHIFT_UP_WR;
      S_SHIFT_UP_WR: state_nxt = (k_r - CNT_W'(1) > idx_r + CNT_W'(1)) ? S_SHIFT_UP_RD : S_SPLIT_WR;
      S_SPLIT_WR: state_nxt = S_OUT;
      S_GROW: state_nxt = S_OUT;
      S_FREE_NEXT_RD: state_nxt = (idx_r + CNT_W'(1) < count_r) ? S_FREE_NEXT_CHK : S_FREE_PREV_RD;
      S_FREE_NEXT_CHK: state_nxt = S_FREE_PREV_RD;
      S_FREE_PREV_RD: state_nxt = (idx_r != '0) ? S_FREE_PREV_CHK : S_CLOSE_RD;
      S_FREE_PREV_CHK: state_nxt = S_CLOSE_RD;
      S_CLOSE_RD: state_nxt = (merged_r && k_r + CNT_W'(1) < count_r) ? S_CLOSE_WR : S_OUT;
      S_CLOSE_WR: state_nxt = S_CLOSE_RD;
      S_OUT: state_nxt = out_ch.ready ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    brk_nxt    = brk_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    oaddr_nxt  = oaddr_r;
    ost_nxt    = ost_r;
    merged_nxt = merged_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r[IDX_W-1:0];
    ram_wdata  = cur_r;
    ram_raddr  = idx_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        idx_nxt    = '0;
        oaddr_nxt  = '0;
        merged_nxt = 1'b0;
        if (in_ch.command == CMD_FREE) begin
          ost_nxt = ST_IGNORED;
        end else begin
          ost_nxt = (in_ch.request_bytes == '0) ? ST_ZERO : ST_NOMEM;
        end
      end
      S_SCAN_RD: ;
      S_SCAN_CHK: begin
        cur_nxt = ram_rdata;
        if (!(cmd_r == CMD_ALLOC ? (ram_rdata.is_free && W'(ram_rdata.size) >= need_r)
                                 : (add_sum == W'(rel_r)))) begin
          idx_nxt = idx_r + CNT_W'(1);
        end
        if (cmd_r == CMD_ALLOC && ram_rdata.is_free && W'(ram_rdata.size) >= need_r) begin
          oaddr_nxt = ADDR_W'(add_sum);
          ost_nxt   = ST_DONE;
          ram_we    = 1'b1;
          ram_wdata = '{offset: ram_rdata.offset, size: ram_rdata.size, is_free: 1'b0};
        end
        if (cmd_r == CMD_FREE && add_sum == W'(rel_r) && !ram_rdata.is_free) begin
          ost_nxt   = ST_DONE;
          cur_nxt.is_free = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = '{offset: ram_rdata.offset, size: ram_rdata.size, is_free: 1'b1};
        end
        oaddr_nxt = (cmd_r == CMD_ALLOC && ram_rdata.is_free && W'(ram_rdata.size) >= need_r)
                    ? ADDR_W'(W'(ram_rdata.offset) + HDR) : '0;
      end
      S_SPLIT_PREP: begin
        k_nxt = count_r;
        cur_nxt.offset = ADDR_W'(add_sum);
        if (W'(cur_r.size) >= need_r + HDR + W'(8) && count_r < CNT_W'(MAX_BLOCKS)) begin
          ram_we    = 1'b1;
          ram_wdata = '{offset: cur_r.offset, size: ADDR_W'(need_r), is_free: 1'b0};
        end
      end
      S_SHIFT_UP_RD: ram_raddr = IDX_W'(k_r - CNT_W'(1));
      S_SHIFT_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        k_nxt     = k_r - CNT_W'(1);
      end
      S_SPLIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(idx_r + CNT_W'(1));
        ram_wdata = '{offset: cur_r.offset, size: ADDR_W'(add_sum), is_free: 1'b1};
        count_nxt = count_r + CNT_W'(1);
      end
      S_GROW: begin
        if (count_r < CNT_W'(MAX_BLOCKS) && add_sum <= eff_lim) begin
          ram_we    = 1'b1;
          ram_waddr = count_r[IDX_W-1:0];
          ram_wdata = '{offset: brk_r, size: ADDR_W'(need_r), is_free: 1'b0};
          count_nxt = count_r + CNT_W'(1);
          brk_nxt   = ADDR_W'(add_sum);
          oaddr_nxt = ADDR_W'(W'(brk_r) + HDR);
          ost_nxt   = ST_DONE;
        end
      end
      S_FREE_NEXT_RD: ram_raddr = IDX_W'(idx_r + CNT_W'(1));
      S_FREE_NEXT_CHK: begin
        if (ram_rdata.is_free) begin
          cur_nxt.size = ADDR_W'(add_sum);
          ram_we       = 1'b1;
          ram_wdata    = '{offset: cur_r.offset, size: ADDR_W'(add_sum), is_free: 1'b1};
          merged_nxt   = 1'b1;
          k_nxt        = idx_r + CNT_W'(1);
        end
      end
      S_FREE_PREV_RD: ram_raddr = IDX_W'(idx_r - CNT_W'(1));
      S_FREE_PREV_CHK: begin
        if (ram_rdata.is_free) begin
          ram_we     = 1'b1;
          ram_waddr  = IDX_W'(idx_r - CNT_W'(1));
          ram_wdata  = '{offset: ram_rdata.offset, size: ADDR_W'(add_sum), is_free: 1'b1};
          if (merged_r) begin
            // close two slots: shift by two starting at idx
            k_nxt = idx_r;
            count_nxt = count_r - CNT_W'(1);
          end else begin
            k_nxt = idx_r;
          end
          merged_nxt = 1'b1;
        end
      end
      S_CLOSE_RD: begin
        ram_raddr = IDX_W'(k_r + CNT_W'(1) + CNT_W'(dbl_r));
        if (!(merged_r && k_r + CNT_W'(1) < count_r) && merged_r) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_CLOSE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        k_nxt     = k_r + CNT_W'(1);
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= ADDR_W'(65536);
      count_r     <= '0;
      brk_r       <= '0;
      merged_r    <= 1'b0;
      dbl_r       <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      brk_r    <= brk_nxt;
      merged_r <= merged_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_r <= cfg_ch.data;
      end
      if (state_r == S_IDLE) begin
        dbl_r <= 1'b0;
      end else if (state_r == S_FREE_PREV_CHK && ram_rdata.is_free && merged_r) begin
        dbl_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    cur_r   <= cur_nxt;
    oaddr_r <= oaddr_nxt;
    ost_r   <= ost_nxt;
    if (in_acc) begin
      cmd_r  <= in_ch.command;
      need_r <= need_in;
      rel_r  <= in_ch.release_address;
    end
  end

endmodule

FILE: hdl/first_fit_heap_allocator_unit.sv
// request path: the time from request to result is set by the table walk
//   and the entry shift on split or merge
// flow: one request at a time; ready only while idle, so a new request is taken
//   only after the previous result has been accepted
// reset: rst_n synchronous active low; empties the table, clears the break and
//   sets heap_limit to 65536; table contents are not cleared
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ffha_in_if.sink    in_ch,
  ffha_out_if.source out_ch,
  ffha_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  ffha_entry_t       ram_wdata, ram_rdata;

  ffha_ctrl #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_ch   (cfg_ch),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata)
  );

  ffha_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
